/* design/wgm_pkg.sv */
// Shared types and constants for the wildcard glob matcher.
// Used by wgm_ctrl, wgm_cell and wildcard_glob_matcher_core; no dependencies.
`default_nettype none
package wgm_pkg;

  // transaction opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_FEED   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // pattern wildcards
  localparam logic [7:0] SYM_ONE = 8'd63;  // '?'
  localparam logic [7:0] SYM_ANY = 8'd42;  // '*'

  // token handed from one cell to the next during a sweep
  typedef struct packed {
    logic tok;    // this cell updates now
    logic carry;  // new match bit of the left neighbor
    logic prev;   // old match bit of the left neighbor
  } link_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       restart;  // sweep rebuilds the star prefix
    logic [7:0] text;     // text symbol of the current sweep
    logic       wr_en;    // pattern append this cycle
    logic [7:0] wr_sym;   // symbol being appended
  } ctl_t;

endpackage
`default_nettype wire

/* design/wgm_cell.sv */
// One pattern position: stored symbol and its prefix match bit.
// Depends on wgm_pkg; instantiated in a row by wildcard_glob_matcher_core.
`default_nettype none
module wgm_cell import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 64,
  parameter int IDX         = 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ctl_t                               ctl_i,
  input  wire logic [$clog2(PATTERN_MAX+1)-1:0]   len_i,
  input  wire link_t                              link_i,
  output link_t                                   link_o,
  output logic                                    bit_o
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam logic [LW-1:0] IDX_L = LW'(IDX);
  localparam logic [LW-1:0] WR_AT = LW'(IDX - 1);

  logic [7:0] sym_q;
  logic       bit_q, bit_d;
  link_t      link_q;
  logic       is_star, is_one;

  // pattern symbol capture on append at this position
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (len_i == WR_AT)) begin
      sym_q <= ctl_i.wr_sym;
    end
  end

  // next match bit for this prefix
  always_comb begin
    is_star = (sym_q == SYM_ANY);
    is_one  = (sym_q == SYM_ONE);
    if (ctl_i.restart) begin
      bit_d = link_i.carry & is_star;
    end else if (is_star) begin
      bit_d = bit_q | link_i.carry;
    end else if (is_one || (sym_q == ctl_i.text)) begin
      bit_d = link_i.prev;
    end else begin
      bit_d = 1'b0;
    end
  end

  // update on token, hand token on while inside the pattern
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= 1'b0;
      link_q <= '0;
    end else begin
      if (link_i.tok) begin
        bit_q <= bit_d;
      end
      link_q.tok   <= link_i.tok & (IDX_L < len_i);
      link_q.carry <= bit_d;
      link_q.prev  <= bit_q;
    end
  end

  assign link_o = link_q;
  assign bit_o  = bit_q;

endmodule
`default_nettype wire

/* design/wgm_ctrl.sv */
// Sequencer: input/output handshake, pattern length, empty-prefix bit, sweep count.
// Depends on wgm_pkg; drives the cell row in wildcard_glob_matcher_core.
`default_nettype none
module wgm_ctrl import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         op_i,
  input  wire logic [7:0]                         symbol_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    matched_o,
  output logic                                    pattern_overflow_o,
  input  wire logic [PATTERN_MAX:1]               row_i,
  output logic [$clog2(PATTERN_MAX+1)-1:0]        len_o,
  output ctl_t                                    ctl_o,
  output link_t                                   link_o
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(PATTERN_MAX);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic          state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          zero_q, zero_d;
  logic          restart_q, restart_d;
  logic [7:0]    text_q;
  logic          ovf_q, ovf_d;
  logic          launch;
  link_t         link_q, link_d;
  logic          out_valid_q, out_valid_d;
  logic          matched_q, matched_d;
  logic          oflow_q, oflow_d;
  logic          accept, full, done;
  logic [PATTERN_MAX:0] row;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign full       = (len_q == LEN_FULL);
  assign row        = {row_i, zero_q};
  assign done       = (state_q == ST_SWEEP) && (cnt_q == len_q) &&
                      (!out_valid_q || out_ready_i);

  // decode the incoming transaction
  always_comb begin
    len_d     = len_q;
    zero_d    = zero_q;
    restart_d = restart_q;
    ovf_d     = ovf_q;
    launch    = 1'b0;
    if (accept) begin
      ovf_d = 1'b0;
      case (op_i)
        OP_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LW'(1);
          end
          zero_d    = 1'b1;
          restart_d = 1'b1;
          launch    = 1'b1;
        end
        OP_FEED: begin
          zero_d    = 1'b0;
          restart_d = 1'b0;
          launch    = 1'b1;
        end
        OP_CLEAR: begin
          len_d     = '0;
          zero_d    = 1'b1;
          restart_d = 1'b1;
          launch    = 1'b1;
        end
        default: begin
          launch = 1'b0;
        end
      endcase
    end
  end

  // first link of the chain and sweep sequencing
  always_comb begin
    link_d.tok   = launch & (len_d != '0);
    link_d.carry = zero_d;
    link_d.prev  = zero_q;
    state_d      = state_q;
    cnt_d        = cnt_q;
    if (accept) begin
      state_d = ST_SWEEP;
      cnt_d   = '0;
    end else if (done) begin
      state_d = ST_IDLE;
    end else if ((state_q == ST_SWEEP) && (cnt_q != len_q)) begin
      cnt_d = cnt_q + LW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    oflow_d     = oflow_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (done) begin
      out_valid_d = 1'b1;
      matched_d   = row[len_q];
      oflow_d     = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      zero_q      <= 1'b1;
      restart_q   <= 1'b1;
      ovf_q       <= 1'b0;
      link_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      restart_q   <= restart_d;
      ovf_q       <= ovf_d;
      link_q      <= link_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      text_q <= symbol_i;
    end
    matched_q <= matched_d;
    oflow_q   <= oflow_d;
  end

  assign ctl_o.restart      = restart_q;
  assign ctl_o.text         = text_q;
  assign ctl_o.wr_en        = accept && (op_i == OP_APPEND) && !full;
  assign ctl_o.wr_sym       = symbol_i;
  assign len_o              = len_q;
  assign link_o             = link_q;
  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = oflow_q;

endmodule
`default_nettype wire

/* design/wildcard_glob_matcher_core.sv */
// Top level of the wildcard glob matcher: sequencer plus a row of pattern cells.
// Depends on wgm_pkg, wgm_ctrl and wgm_cell.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid_i/in_ready_o | op_i, symbol_i
//   out     | output    | out_valid_o/out_ready_i | matched_o, pattern_overflow_o
//
// One transaction at a time: a token walks the cell row one cell per cycle up
// to the pattern length L after the item is accepted. The result is presented
// when the sweep ends, and the next item is accepted only after that, once the
// sequencer is back in idle. After reset the pattern is empty and the text
// restarted. A result held by a stalled output does not block the next accept;
// the next result waits in the sweep until the output register frees.
`default_nettype none
module wildcard_glob_matcher_core import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] symbol_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            matched_o,
  output logic            pattern_overflow_o
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  ctl_t                 ctl;
  logic [LW-1:0]        len;
  link_t                links [0:PATTERN_MAX];
  logic [PATTERN_MAX:1] row;

  // sequencer and empty-prefix bit
  wgm_ctrl #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .symbol_i           (symbol_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o),
    .row_i              (row),
    .len_o              (len),
    .ctl_o              (ctl),
    .link_o             (links[0])
  );

  // row of pattern cells, one per pattern position
  for (genvar g = 1; g <= PATTERN_MAX; g++) begin : g_cell
    wgm_cell #(
      .PATTERN_MAX(PATTERN_MAX),
      .IDX        (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .len_i  (len),
      .link_i (links[g-1]),
      .link_o (links[g]),
      .bit_o  (row[g])
    );
  end

endmodule
`default_nettype wire

/* bench/tb_wildcard_glob_matcher_core.sv */
// Self-checking bench for wildcard_glob_matcher_core: directed and random glob traffic.
// Depends on wgm_pkg and the core; predicts every result with an in-bench DP row.
`timescale 1ns / 100ps
module tb_wildcard_glob_matcher_core;
  import wgm_pkg::*;

  localparam int PATTERN_MAX = 64;
  localparam logic [1:0] OP_NOP = 2'd3;  // unused opcode, leaves state alone
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_ITEMS = 150;
  localparam int CYCLE_LIMIT = 900_000;

  typedef struct packed {
    logic matched;
    logic overflow;
  } glob_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] op_i;
  logic [7:0] symbol_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       matched_o;
  logic       pattern_overflow_o;

  // predictor state: stored pattern, its length and one match bit per prefix
  logic [7:0]           glob_sym [PATTERN_MAX];
  int                   glob_len;
  logic [PATTERN_MAX:0] prefix_hit;

  glob_result_t pending_results[$];
  int           mismatch_count;
  int           items_sent;
  int           cycle_count;
  bit           drain_phase;

  wildcard_glob_matcher_core #(
    .PATTERN_MAX(PATTERN_MAX)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .symbol_i           (symbol_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // empty text: prefix j matches only if its first j symbols are all stars
  function automatic void restart_prefixes();
    prefix_hit    = '0;
    prefix_hit[0] = 1'b1;
    for (int j = 1; j <= glob_len; j++) begin
      prefix_hit[j] = prefix_hit[j-1] && (glob_sym[j-1] == SYM_ANY);
    end
  endfunction

  // apply one transaction to the predictor and return the result it causes
  function automatic glob_result_t glob_predict(logic [1:0] op, logic [7:0] sym);
    glob_result_t         res;
    logic [PATTERN_MAX:0] nxt;
    res.overflow = 1'b0;
    case (op)
      OP_APPEND: begin
        if (glob_len >= PATTERN_MAX) begin
          res.overflow = 1'b1;
        end else begin
          glob_sym[glob_len] = sym;
          glob_len++;
        end
        restart_prefixes();
      end
      OP_FEED: begin
        nxt = '0;
        for (int j = 1; j <= glob_len; j++) begin
          if (glob_sym[j-1] == SYM_ANY) begin
            nxt[j] = prefix_hit[j] || nxt[j-1];
          end else if (glob_sym[j-1] == SYM_ONE || glob_sym[j-1] == sym) begin
            nxt[j] = prefix_hit[j-1];
          end
        end
        prefix_hit = nxt;
      end
      OP_CLEAR: begin
        glob_len = 0;
        restart_prefixes();
      end
      default: begin
      end
    endcase
    res.matched = prefix_hit[glob_len];
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // drive one transaction at the falling edge, hold it until accepted
  task automatic send_item(logic [1:0] op, logic [7:0] sym);
    if (!drain_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    op_i       = op;
    symbol_i   = sym;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(glob_predict(op, sym));
    items_sent++;
    @(negedge clk_i);
  endtask

  // pattern symbols lean on a small alphabet so that text can hit them
  function automatic logic [7:0] pick_pattern_sym();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return SYM_ANY;
    if (r == 2) return SYM_ONE;
    if (r == 3) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pick_text_sym();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return SYM_ANY;
    if (r == 1) return SYM_ONE;
    if (r == 2) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  // empty pattern matches only the empty text; unused opcode changes nothing
  task automatic test_empty_pattern();
    send_item(OP_CLEAR, 8'hA5);
    send_item(OP_NOP, 8'h00);
    send_item(OP_FEED, "a");
    send_item(OP_NOP, 8'hFF);
    send_item(OP_CLEAR, 8'h00);
  endtask

  // literals and the single-symbol wildcard
  task automatic test_literals_and_one();
    send_item(OP_APPEND, "a");
    send_item(OP_APPEND, SYM_ONE);
    send_item(OP_APPEND, "c");
    send_item(OP_FEED, "a");
    send_item(OP_FEED, "x");
    send_item(OP_FEED, "c");
    send_item(OP_FEED, "c");
  endtask

  // star matches empty runs, and a star in the text is only a literal
  task automatic test_star();
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_APPEND, SYM_ANY);
    send_item(OP_FEED, SYM_ANY);
    send_item(OP_FEED, 8'hFF);
    send_item(OP_APPEND, "b");
    send_item(OP_FEED, "b");
    send_item(OP_FEED, SYM_ANY);
    send_item(OP_FEED, SYM_ONE);
  endtask

  // symbol extremes as literals
  task automatic test_symbol_extremes();
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_FEED, 8'h00);
    send_item(OP_FEED, 8'hFF);
  endtask

  // full pattern store: appends are dropped but still restart the text
  task automatic test_overflow();
    logic [7:0] lit [PATTERN_MAX];
    send_item(OP_CLEAR, 8'h00);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      send_item(OP_APPEND, (k == PATTERN_MAX - 2) ? SYM_ONE : SYM_ANY);
    end
    send_item(OP_APPEND, "z");
    send_item(OP_FEED, "q");
    send_item(OP_APPEND, SYM_ANY);
    repeat (3) send_item(OP_FEED, pick_text_sym());
    send_item(OP_CLEAR, 8'h00);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      lit[k] = 8'("a" + $urandom_range(0, 2));
      send_item(OP_APPEND, lit[k]);
    end
    send_item(OP_APPEND, 8'hFF);
    for (int k = 0; k < PATTERN_MAX; k++) send_item(OP_FEED, lit[k]);
    send_item(OP_FEED, "a");
    send_item(OP_CLEAR, 8'h00);
  endtask

  // well-formed pattern/text pairs, mostly short, plus raw noise
  task automatic run_glob_sequences(int n_items);
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int         stop_at;
    int         plen;
    logic [7:0] sym;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        pat.delete();
        txt.delete();
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 39) == 0) ? $urandom_range(40, PATTERN_MAX + 2)
                                            : $urandom_range(0, 8);
        for (int k = 0; k < plen; k++) begin
          sym = pick_pattern_sym();
          if (k < PATTERN_MAX) pat.push_back(sym);
          send_item(OP_APPEND, sym);
        end
        // text built to fit the pattern half the time
        if ($urandom_range(0, 1) == 1) begin
          foreach (pat[k]) begin
            if (pat[k] == SYM_ANY) begin
              repeat ($urandom_range(0, 3)) txt.push_back(pick_text_sym());
            end else if (pat[k] == SYM_ONE) begin
              txt.push_back(pick_text_sym());
            end else begin
              txt.push_back(pat[k]);
            end
          end
          if (txt.size() > 0 && $urandom_range(0, 3) == 0) begin
            txt[$urandom_range(0, txt.size() - 1)] = pick_text_sym();
          end
        end else begin
          repeat ($urandom_range(0, 10)) txt.push_back(pick_text_sym());
        end
        foreach (txt[k]) send_item(OP_FEED, txt[k]);
        if ($urandom_range(0, 4) == 0) send_item(OP_NOP, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // output side stalls in bursts until the drain phase
  initial begin
    out_ready_i = 1'b0;
    forever begin
      if (drain_phase) begin
        out_ready_i = 1'b1;
        @(negedge clk_i);
      end else if ($urandom_range(0, 7) < 2) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
        repeat ($urandom_range(1, 32)) @(negedge clk_i);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    glob_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, matched", -1, int'(matched_o));
      end else begin
        want = pending_results.pop_front();
        if (matched_o !== want.matched) begin
          report_mismatch("matched", int'(want.matched), int'(matched_o));
        end
        if (pattern_overflow_o !== want.overflow) begin
          report_mismatch("pattern_overflow", int'(want.overflow), int'(pattern_overflow_o));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OP_CLEAR;
    symbol_i       = 8'h00;
    drain_phase    = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    glob_len       = 0;
    restart_prefixes();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_pattern();
    test_literals_and_one();
    test_star();
    test_symbol_extremes();
    test_overflow();
    run_glob_sequences(RANDOM_ITEMS);
    drain_phase = 1'b1;
    run_glob_sequences(DRAIN_ITEMS);
    in_valid_i = 1'b0;

    // let the last sweeps finish, then look for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * PATTERN_MAX + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
